FILE: rtl/ptd_pkg.sv
package ptd_pkg;

    localparam int COORD_W = 16;
    localparam int N_FIELDS = 12;
    localparam int IN_W = N_FIELDS * COORD_W;

    localparam int DIFF_W = COORD_W + 1;
    localparam int DOT_W = 2 * DIFF_W + 2;
    localparam int CRS_W = 2 * DIFF_W + 1;
    localparam int VOL_W = 2 * DOT_W + 1;
    localparam int DD_W = VOL_W + 2;
    localparam int S_W = CRS_W + DIFF_W + 2;
    localparam int SH_W = S_W / 2 + S_W % 2;
    localparam int S2_W = 4 * SH_W;
    localparam int EN_W = 2 * DOT_W + 1;

    localparam int NUM_MAX_W = (S2_W > EN_W) ? S2_W : EN_W;
    localparam int NUM_W = NUM_MAX_W + 2;
    localparam int DEN_W = (DD_W > DOT_W) ? DD_W : DOT_W;
    localparam int DV_W = DEN_W + 1;
    localparam int RM_W = DV_W + 1;

    localparam int OUT_W = 34;
    localparam int Q_W = OUT_W + 1;
    localparam int TOP_W = NUM_W - Q_W;
    localparam int ODATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int RGN_W = 3;
    localparam int OUSER_W = RGN_W + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [OUT_W-1:0] DIST_MAX = {OUT_W{1'b1}};

    localparam logic [RGN_W-1:0] RGN_VERT_A = 3'd0;
    localparam logic [RGN_W-1:0] RGN_VERT_B = 3'd1;
    localparam logic [RGN_W-1:0] RGN_EDGE_AB = 3'd2;
    localparam logic [RGN_W-1:0] RGN_VERT_C = 3'd3;
    localparam logic [RGN_W-1:0] RGN_EDGE_AC = 3'd4;
    localparam logic [RGN_W-1:0] RGN_EDGE_BC = 3'd5;
    localparam logic [RGN_W-1:0] RGN_FACE = 3'd6;

    typedef logic signed [COORD_W-1:0] ptd_crd_t;
    typedef logic signed [DIFF_W-1:0] ptd_diff_t;
    typedef logic signed [DOT_W-1:0] ptd_dot_t;

    typedef struct packed {
        ptd_crd_t x;
        ptd_crd_t y;
        ptd_crd_t z;
    } ptd_cvec_t;

    typedef struct packed {
        ptd_diff_t x;
        ptd_diff_t y;
        ptd_diff_t z;
    } ptd_vec_t;

    typedef struct packed {
        logic signed [CRS_W-1:0] x;
        logic signed [CRS_W-1:0] y;
        logic signed [CRS_W-1:0] z;
    } ptd_cross_t;

    typedef struct packed {
        ptd_dot_t d1;
        ptd_dot_t d2;
        ptd_dot_t d3;
        ptd_dot_t d4;
        ptd_dot_t d5;
        ptd_dot_t d6;
        ptd_dot_t ap2;
        ptd_dot_t bp2;
        ptd_dot_t cp2;
    } ptd_dots_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [RGN_W-1:0] region;
        logic degen;
        logic vert;
        logic [OUT_W-1:0] vdist;
        ptd_dot_t q2;
        ptd_dot_t qe;
        ptd_dot_t eden;
        logic intr;
        logic [S2_W-1:0] s2;
        logic [DD_W-1:0] dd;
    } ptd_job_t;

    // result side info that rides along the divider
    typedef struct packed {
        logic [RGN_W-1:0] region;
        logic degen;
        logic fixed;
        logic [OUT_W-1:0] fdist;
    } ptd_tag_t;

    function automatic ptd_vec_t vsub(input ptd_cvec_t u, input ptd_cvec_t v);
        ptd_vec_t r;
        r.x = DIFF_W'(u.x) - DIFF_W'(v.x);
        r.y = DIFF_W'(u.y) - DIFF_W'(v.y);
        r.z = DIFF_W'(u.z) - DIFF_W'(v.z);
        return r;
    endfunction

    function automatic ptd_dot_t dot3(input ptd_vec_t u, input ptd_vec_t v);
        logic signed [2*DIFF_W-1:0] px;
        logic signed [2*DIFF_W-1:0] py;
        logic signed [2*DIFF_W-1:0] pz;
        px = u.x * v.x;
        py = u.y * v.y;
        pz = u.z * v.z;
        return DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
    endfunction

    function automatic ptd_cross_t cross3(input ptd_vec_t u, input ptd_vec_t v);
        logic signed [2*DIFF_W-1:0] p1;
        logic signed [2*DIFF_W-1:0] p2;
        logic signed [2*DIFF_W-1:0] p3;
        logic signed [2*DIFF_W-1:0] p4;
        logic signed [2*DIFF_W-1:0] p5;
        logic signed [2*DIFF_W-1:0] p6;
        ptd_cross_t r;
        p1 = u.y * v.z;
        p2 = u.z * v.y;
        p3 = u.z * v.x;
        p4 = u.x * v.z;
        p5 = u.x * v.y;
        p6 = u.y * v.x;
        r.x = CRS_W'(p1) - CRS_W'(p2);
        r.y = CRS_W'(p3) - CRS_W'(p4);
        r.z = CRS_W'(p5) - CRS_W'(p6);
        return r;
    endfunction

    function automatic logic signed [S_W-1:0] dot_nv(input ptd_cross_t n, input ptd_vec_t v);
        logic signed [CRS_W+DIFF_W-1:0] px;
        logic signed [CRS_W+DIFF_W-1:0] py;
        logic signed [CRS_W+DIFF_W-1:0] pz;
        px = n.x * v.x;
        py = n.y * v.y;
        pz = n.z * v.z;
        return S_W'(px) + S_W'(py) + S_W'(pz);
    endfunction

    // squared length clamped into the output range
    function automatic logic [OUT_W-1:0] clamp_dist(input ptd_dot_t v);
        logic [OUT_W-1:0] r;
        if (v[DOT_W-1])
        begin
            r = '0;
        end
        else if (|v[DOT_W-2:OUT_W])
        begin
            r = DIST_MAX;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/ptd_front.sv
module ptd_front
    import ptd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ce,
    input  logic            in_valid,
    input  logic [IN_W-1:0] in_data,
    output logic            out_valid,
    output ptd_job_t        out_job
);

    ptd_cvec_t pt;
    ptd_cvec_t va_in;
    ptd_cvec_t vb_in;
    ptd_cvec_t vc_in;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: edge and point vectors
    ptd_vec_t ab_reg, ac_reg, ap_reg, bp_reg, cp_reg;
    // stage 2: dot and cross products
    ptd_dots_t dots2_reg;
    ptd_cross_t n_reg;
    ptd_vec_t ap2v_reg;
    // stage 3: dot pair products and normal projection
    logic signed [2*DOT_W-1:0] m14_reg, m32_reg, m52_reg, m16_reg, m36_reg, m54_reg;
    logic signed [2*DOT_W-1:0] m14_next, m32_next, m52_next, m16_next, m36_next, m54_next;
    logic signed [S_W-1:0] s_reg;
    ptd_dots_t dots3_reg;
    // stage 4: barycentric volumes and split square of the projection
    logic signed [VOL_W-1:0] va_reg, vb_reg, vc_reg;
    logic [2*SH_W-1:0] sm;
    logic [SH_W-1:0] s_hi;
    logic [SH_W-1:0] s_lo;
    logic [2*SH_W-1:0] hh_reg, hl_reg, ll_reg;
    ptd_dots_t dots4_reg;
    // stage 5: region and operands
    ptd_job_t job_reg;
    ptd_job_t job_next;

    logic [S2_W-1:0] s2;
    logic signed [DD_W-1:0] dd;
    logic signed [DOT_W:0] d43;
    logic signed [DOT_W:0] d56;
    logic signed [DOT_W:0] den_ab;
    logic signed [DOT_W:0] den_ac;
    logic signed [DOT_W+1:0] den_bc;

    always_comb
    begin
        pt.x = in_data[0*COORD_W +: COORD_W];
        pt.y = in_data[1*COORD_W +: COORD_W];
        pt.z = in_data[2*COORD_W +: COORD_W];
        va_in.x = in_data[3*COORD_W +: COORD_W];
        va_in.y = in_data[4*COORD_W +: COORD_W];
        va_in.z = in_data[5*COORD_W +: COORD_W];
        vb_in.x = in_data[6*COORD_W +: COORD_W];
        vb_in.y = in_data[7*COORD_W +: COORD_W];
        vb_in.z = in_data[8*COORD_W +: COORD_W];
        vc_in.x = in_data[9*COORD_W +: COORD_W];
        vc_in.y = in_data[10*COORD_W +: COORD_W];
        vc_in.z = in_data[11*COORD_W +: COORD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign m14_next = dots2_reg.d1 * dots2_reg.d4;
    assign m32_next = dots2_reg.d3 * dots2_reg.d2;
    assign m52_next = dots2_reg.d5 * dots2_reg.d2;
    assign m16_next = dots2_reg.d1 * dots2_reg.d6;
    assign m36_next = dots2_reg.d3 * dots2_reg.d6;
    assign m54_next = dots2_reg.d5 * dots2_reg.d4;

    assign sm   = (2*SH_W)'($unsigned(s_reg[S_W-1] ? -s_reg : s_reg));
    assign s_hi = sm[2*SH_W-1:SH_W];
    assign s_lo = sm[SH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ab_reg <= vsub(vb_in, va_in);
            ac_reg <= vsub(vc_in, va_in);
            ap_reg <= vsub(pt, va_in);
            bp_reg <= vsub(pt, vb_in);
            cp_reg <= vsub(pt, vc_in);

            dots2_reg.d1  <= dot3(ab_reg, ap_reg);
            dots2_reg.d2  <= dot3(ac_reg, ap_reg);
            dots2_reg.d3  <= dot3(ab_reg, bp_reg);
            dots2_reg.d4  <= dot3(ac_reg, bp_reg);
            dots2_reg.d5  <= dot3(ab_reg, cp_reg);
            dots2_reg.d6  <= dot3(ac_reg, cp_reg);
            dots2_reg.ap2 <= dot3(ap_reg, ap_reg);
            dots2_reg.bp2 <= dot3(bp_reg, bp_reg);
            dots2_reg.cp2 <= dot3(cp_reg, cp_reg);
            n_reg         <= cross3(ab_reg, ac_reg);
            ap2v_reg      <= ap_reg;

            m14_reg   <= m14_next;
            m32_reg   <= m32_next;
            m52_reg   <= m52_next;
            m16_reg   <= m16_next;
            m36_reg   <= m36_next;
            m54_reg   <= m54_next;
            s_reg     <= dot_nv(n_reg, ap2v_reg);
            dots3_reg <= dots2_reg;

            vc_reg    <= VOL_W'(m14_reg) - VOL_W'(m32_reg);
            vb_reg    <= VOL_W'(m52_reg) - VOL_W'(m16_reg);
            va_reg    <= VOL_W'(m36_reg) - VOL_W'(m54_reg);
            hh_reg    <= s_hi * s_hi;
            hl_reg    <= s_hi * s_lo;
            ll_reg    <= s_lo * s_lo;
            dots4_reg <= dots3_reg;

            job_reg <= job_next;
        end
    end

    assign s2 = (S2_W'(hh_reg) << (2 * SH_W)) + (S2_W'(hl_reg) << (SH_W + 1)) + S2_W'(ll_reg);
    assign dd = DD_W'(va_reg) + DD_W'(vb_reg) + DD_W'(vc_reg);

    assign d43    = (DOT_W+1)'(dots4_reg.d4) - (DOT_W+1)'(dots4_reg.d3);
    assign d56    = (DOT_W+1)'(dots4_reg.d5) - (DOT_W+1)'(dots4_reg.d6);
    assign den_ab = (DOT_W+1)'(dots4_reg.d1) - (DOT_W+1)'(dots4_reg.d3);
    assign den_ac = (DOT_W+1)'(dots4_reg.d2) - (DOT_W+1)'(dots4_reg.d6);
    assign den_bc = (DOT_W+2)'(d43) + (DOT_W+2)'(d56);

    // tests in the order of the closest-feature search
    always_comb
    begin
        job_next.region = RGN_FACE;
        job_next.degen  = 1'b0;
        job_next.vert   = 1'b0;
        job_next.vdist  = clamp_dist(dots4_reg.ap2);
        job_next.q2     = dots4_reg.ap2;
        job_next.qe     = dots4_reg.d1;
        job_next.eden   = den_ab[DOT_W-1:0];
        job_next.intr   = 1'b0;
        job_next.s2     = s2;
        job_next.dd     = $unsigned(dd);
        priority if (dots4_reg.d1 <= 0 && dots4_reg.d2 <= 0)
        begin
            job_next.region = RGN_VERT_A;
            job_next.vert   = 1'b1;
        end
        else if (dots4_reg.d3 >= 0 && dots4_reg.d4 <= dots4_reg.d3)
        begin
            job_next.region = RGN_VERT_B;
            job_next.vert   = 1'b1;
            job_next.vdist  = clamp_dist(dots4_reg.bp2);
        end
        else if (vc_reg <= 0 && dots4_reg.d1 >= 0 && dots4_reg.d3 <= 0)
        begin
            job_next.region = RGN_EDGE_AB;
            job_next.degen  = (den_ab <= 0);
        end
        else if (dots4_reg.d6 >= 0 && dots4_reg.d5 <= dots4_reg.d6)
        begin
            job_next.region = RGN_VERT_C;
            job_next.vert   = 1'b1;
            job_next.vdist  = clamp_dist(dots4_reg.cp2);
        end
        else if (vb_reg <= 0 && dots4_reg.d2 >= 0 && dots4_reg.d6 <= 0)
        begin
            job_next.region = RGN_EDGE_AC;
            job_next.degen  = (den_ac <= 0);
            job_next.qe     = dots4_reg.d2;
            job_next.eden   = den_ac[DOT_W-1:0];
        end
        else if (va_reg <= 0 && d43 >= 0 && d56 >= 0)
        begin
            job_next.region = RGN_EDGE_BC;
            job_next.degen  = (den_bc <= 0);
            job_next.q2     = dots4_reg.bp2;
            job_next.qe     = d43[DOT_W-1:0];
            job_next.eden   = den_bc[DOT_W-1:0];
        end
        else
        begin
            job_next.region = RGN_FACE;
            job_next.intr   = 1'b1;
            job_next.degen  = (dd <= 0);
        end
    end

    assign out_valid = v5_reg;
    assign out_job   = job_reg;

endmodule

FILE: rtl/ptd_fifo.sv
module ptd_fifo
    import ptd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ptd_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     valid,
    output ptd_job_t head
);

    ptd_job_t mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0] count_reg;
    logic [FIFO_AW:0] count_next;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/ptd_back.sv
module ptd_back
    import ptd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  ptd_job_t           job,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [OUT_W-1:0]   m_dist,
    output logic [RGN_W-1:0]   m_region,
    output logic               m_degen
);

    logic ce;

    logic b1_v_reg, b2_v_reg, b3_v_reg;
    logic signed [2*DOT_W-1:0] p1_reg, p2_reg;
    logic [S2_W-1:0] s2_b1_reg;
    logic [DD_W-1:0] dd_b1_reg;
    ptd_dot_t eden_b1_reg;
    logic intr_b1_reg;
    ptd_tag_t tag_b1_reg, tag_b1_next;

    logic signed [EN_W-1:0] en;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    ptd_tag_t tag_b2_reg, tag_b2_next;

    logic [NUM_W-1:0] nn_reg;
    logic [DV_W-1:0] dv_reg;
    ptd_tag_t tag_b3_reg;

    logic [RM_W-1:0] top_ext;
    logic sat;
    ptd_tag_t tag_b4_next;

    // divider pipe, index 0 holds the seeded remainder
    logic             dv_v_reg   [Q_W+1];
    logic [RM_W-1:0]  rem_reg    [Q_W+1];
    logic [Q_W-1:0]   lo_reg     [Q_W+1];
    logic [Q_W-1:0]   q_reg      [Q_W+1];
    logic [DV_W-1:0]  dvs_reg    [Q_W+1];
    ptd_tag_t         tags_reg   [Q_W+1];

    logic out_v_reg;
    logic [OUT_W-1:0] dist_reg, dist_next;
    logic [RGN_W-1:0] region_reg;
    logic degen_reg;

    assign ce      = !out_v_reg || m_ready;
    assign job_pop = ce && job_valid;

    always_comb
    begin
        tag_b1_next.region = job.region;
        tag_b1_next.degen  = job.degen;
        tag_b1_next.fixed  = job.vert || job.degen;
        tag_b1_next.fdist  = job.degen ? DIST_MAX : job.vdist;
    end

    assign en = EN_W'(p1_reg) - EN_W'(p2_reg);

    always_comb
    begin
        tag_b2_next = tag_b1_reg;
        if (intr_b1_reg)
        begin
            num_next = NUM_W'(s2_b1_reg);
            den_next = DEN_W'(dd_b1_reg);
        end
        else
        begin
            num_next = NUM_W'($unsigned(en));
            den_next = DEN_W'($unsigned(eden_b1_reg));
            if (en < 0 && !tag_b1_reg.fixed)
            begin
                tag_b2_next.fixed = 1'b1;
                tag_b2_next.fdist = '0;
            end
        end
    end

    // quotient that needs more than Q_W bits saturates
    assign top_ext = RM_W'(nn_reg[NUM_W-1:Q_W]);
    assign sat     = (top_ext >= RM_W'(dv_reg));

    always_comb
    begin
        tag_b4_next = tag_b3_reg;
        if (sat && !tag_b3_reg.fixed)
        begin
            tag_b4_next.fixed = 1'b1;
            tag_b4_next.fdist = DIST_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            b3_v_reg  <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            b1_v_reg  <= job_valid;
            b2_v_reg  <= b1_v_reg;
            b3_v_reg  <= b2_v_reg;
            dv_v_reg[0] <= b3_v_reg;
            out_v_reg <= dv_v_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg      <= job.q2 * job.eden;
            p2_reg      <= job.qe * job.qe;
            s2_b1_reg   <= job.s2;
            dd_b1_reg   <= job.dd;
            eden_b1_reg <= job.eden;
            intr_b1_reg <= job.intr;
            tag_b1_reg  <= tag_b1_next;

            num_reg    <= num_next;
            den_reg    <= den_next;
            tag_b2_reg <= tag_b2_next;

            nn_reg     <= (num_reg << 1) + NUM_W'(den_reg);
            dv_reg     <= {den_reg, 1'b0};
            tag_b3_reg <= tag_b2_reg;

            rem_reg[0]  <= top_ext;
            lo_reg[0]   <= nn_reg[Q_W-1:0];
            q_reg[0]    <= '0;
            dvs_reg[0]  <= dv_reg;
            tags_reg[0] <= tag_b4_next;

            dist_reg   <= dist_next;
            region_reg <= tags_reg[Q_W].region;
            degen_reg  <= tags_reg[Q_W].degen;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar i = 0; i < Q_W; i++)
    begin : g_div
        logic [RM_W-1:0] trial;
        logic ge;

        assign trial = {rem_reg[i][RM_W-2:0], lo_reg[i][Q_W-1]};
        assign ge    = (trial >= RM_W'(dvs_reg[i]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[i+1] <= 1'b0;
            end
            else if (ce)
            begin
                dv_v_reg[i+1] <= dv_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i+1]  <= ge ? (trial - RM_W'(dvs_reg[i])) : trial;
                lo_reg[i+1]   <= {lo_reg[i][Q_W-2:0], 1'b0};
                q_reg[i+1]    <= {q_reg[i][Q_W-2:0], ge};
                dvs_reg[i+1]  <= dvs_reg[i];
                tags_reg[i+1] <= tags_reg[i];
            end
        end
    end

    always_comb
    begin
        if (tags_reg[Q_W].fixed)
        begin
            dist_next = tags_reg[Q_W].fdist;
        end
        else if (q_reg[Q_W][Q_W-1])
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = q_reg[Q_W][OUT_W-1:0];
        end
    end

    assign m_valid  = out_v_reg;
    assign m_dist   = dist_reg;
    assign m_region = region_reg;
    assign m_degen  = degen_reg;

endmodule

FILE: rtl/point_triangle_distance_squared_core.sv
// squared distance from a query point to a triangle, signed Q8.8 in, Q.16 out
// slave channel: one transfer carries the point and the three vertices
// master channel: one transfer per item with the squared distance in tdata
// and the closest-feature region plus the degenerate flag in tuser
// throughput is one item per clock while m_axis_tready is high; the front
// pipeline (5 stages) classifies the point, a 4-deep queue decouples it from
// the back pipeline, which forms the edge or face numerator and runs a
// 35-stage restoring divider
// a vertex result passes the divider unchanged to keep order
// reset clears all valid flags and the queue; no payload is reset
// when m_axis_tready is low the back pipeline holds, the queue fills and
// s_axis_tready drops once the queue is full, so nothing is lost
module point_triangle_distance_squared_core
    import ptd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // dist_squared, zero pad
    output logic [ODATA_W-1:0]  m_axis_tdata,
    // region, degenerate
    output logic [OUSER_W-1:0]  m_axis_tuser
);

    logic front_valid;
    ptd_job_t front_job;
    logic q_full;
    logic q_valid;
    logic q_pop;
    ptd_job_t q_head;
    logic [OUT_W-1:0] sq_dist;
    logic [RGN_W-1:0] region;
    logic degen;

    assign s_axis_tready = !q_full;

    ptd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (s_axis_tready),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (front_valid),
        .out_job   (front_job)
    );

    ptd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid && !q_full),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    ptd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_head),
        .job_pop   (q_pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_dist    (sq_dist),
        .m_region  (region),
        .m_degen   (degen)
    );

    assign m_axis_tdata = ODATA_W'(sq_dist);
    assign m_axis_tuser = {degen, region};

endmodule

FILE: rtl/ptd_checker.sv
module ptd_checker
    import ptd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [ODATA_W-1:0]  m_axis_tdata,
    input logic [OUSER_W-1:0]  m_axis_tuser
);

    logic [RGN_W-1:0] rgn;
    logic dg;

    assign rgn = m_axis_tuser[RGN_W-1:0];
    assign dg  = m_axis_tuser[RGN_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dg |-> m_axis_tdata[OUT_W-1:0] == DIST_MAX)
        else $error("degenerate result not saturated");

    a_degen_region: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dg |->
            rgn == RGN_EDGE_AB || rgn == RGN_EDGE_AC || rgn == RGN_EDGE_BC
            || rgn == RGN_FACE)
        else $error("degenerate flag on a vertex region");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[ODATA_W-1:OUT_W] == '0 && rgn != 3'd7)
        else $error("bad padding or region code");

endmodule

bind point_triangle_distance_squared_core ptd_checker u_ptd_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import ptd_pkg::*;

    localparam int N_RANDOM = 2000;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [OUT_W-1:0] sq_dist;
        logic [RGN_W-1:0] region;
        logic degen;
    } tri_dist_t;

    typedef logic signed [127:0] wide_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [ODATA_W-1:0] m_axis_tdata;
    logic [OUSER_W-1:0] m_axis_tuser;

    int cycles;

    point_triangle_distance_squared_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    function automatic longint crd(input logic [IN_W-1:0] d, input int k);
        logic signed [COORD_W-1:0] v;
        v = d[k*COORD_W +: COORD_W];
        return longint'(v);
    endfunction

    function automatic longint dot_v(input longint u[3], input longint v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // nearest unit, ties up, clamped at zero and saturated
    function automatic logic [OUT_W-1:0] rounded_ratio(input wide_t num, input wide_t den);
        logic [127:0] q;
        if (num < 0)
            return '0;
        q = (2 * num + den) / (2 * den);
        if (q > {94'd0, DIST_MAX})
            return DIST_MAX;
        return q[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sq_len(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(DIST_MAX))
            return DIST_MAX;
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] line_dist(input longint q[3], input longint qe,
                                                   input longint elen2);
        wide_t num;
        num = wide_t'(dot_v(q, q)) * wide_t'(elen2) - wide_t'(qe) * wide_t'(qe);
        return rounded_ratio(num, wide_t'(elen2));
    endfunction

    function automatic tri_dist_t closest_feature(input logic [IN_W-1:0] d);
        longint p[3], a[3], b[3], c[3];
        longint ab[3], ac[3], ap[3], bp[3], cp[3], n[3];
        longint d1, d2, d3, d4, d5, d6, den, s;
        wide_t va, vb, vc, dd;
        tri_dist_t r;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = crd(d, k);
            a[k] = crd(d, 3 + k);
            b[k] = crd(d, 6 + k);
            c[k] = crd(d, 9 + k);
        end
        for (int k = 0; k < 3; k++)
        begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        d1 = dot_v(ab, ap);
        d2 = dot_v(ac, ap);
        d3 = dot_v(ab, bp);
        d4 = dot_v(ac, bp);
        d5 = dot_v(ab, cp);
        d6 = dot_v(ac, cp);
        vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
        vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
        va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);
        r.degen = 1'b0;
        r.sq_dist = '0;
        if (d1 <= 0 && d2 <= 0)
        begin
            r.region = RGN_VERT_A;
            r.sq_dist = sq_len(dot_v(ap, ap));
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            r.region = RGN_VERT_B;
            r.sq_dist = sq_len(dot_v(bp, bp));
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            r.region = RGN_EDGE_AB;
            den = d1 - d3;
            if (den <= 0)
                r.degen = 1'b1;
            else
                r.sq_dist = line_dist(ap, d1, den);
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            r.region = RGN_VERT_C;
            r.sq_dist = sq_len(dot_v(cp, cp));
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            r.region = RGN_EDGE_AC;
            den = d2 - d6;
            if (den <= 0)
                r.degen = 1'b1;
            else
                r.sq_dist = line_dist(ap, d2, den);
        end
        else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
        begin
            r.region = RGN_EDGE_BC;
            den = (d4 - d3) + (d5 - d6);
            if (den <= 0)
                r.degen = 1'b1;
            else
                r.sq_dist = line_dist(bp, d4 - d3, den);
        end
        else
        begin
            r.region = RGN_FACE;
            dd = va + vb + vc;
            if (dd <= 0)
                r.degen = 1'b1;
            else
            begin
                n[0] = ab[1] * ac[2] - ab[2] * ac[1];
                n[1] = ab[2] * ac[0] - ab[0] * ac[2];
                n[2] = ab[0] * ac[1] - ab[1] * ac[0];
                s = dot_v(n, ap);
                r.sq_dist = rounded_ratio(wide_t'(s) * wide_t'(s), dd);
            end
        end
        if (r.degen)
            r.sq_dist = DIST_MAX;
        return r;
    endfunction

    class distance_board;
        tri_dist_t pending[$];
        int errors;

        task report(input string msg);
            $display("mismatch at cycle %0d: %s", cycles, msg);
            errors++;
        endtask

        function void note_item(input logic [IN_W-1:0] d);
            pending = {pending, closest_feature(d)};
        endfunction

        task check_result(input logic [ODATA_W-1:0] data, input logic [OUSER_W-1:0] user);
            tri_dist_t e;
            if (pending.size() == 0)
            begin
                report("result with nothing outstanding");
                return;
            end
            e = pending.pop_front();
            if (data[OUT_W-1:0] !== e.sq_dist)
                report($sformatf("dist_squared got %0d want %0d", data[OUT_W-1:0],
                                 e.sq_dist));
            if (user[RGN_W-1:0] !== e.region)
                report($sformatf("region got %0d want %0d", user[RGN_W-1:0], e.region));
            if (user[RGN_W] !== e.degen)
                report($sformatf("degenerate got %0b want %0b", user[RGN_W], e.degen));
        endtask
    endclass

    distance_board board = new();

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_W-1:0] pack_item(input shortint v[12]);
        logic [IN_W-1:0] d;
        for (int k = 0; k < 12; k++)
            d[k*COORD_W +: COORD_W] = v[k];
        return d;
    endfunction

    // mostly coordinates near a random center so every region shows up often
    function automatic logic [IN_W-1:0] random_item();
        shortint v[12];
        int mode, span, ctr, pick;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            for (int k = 0; k < 12; k++)
                v[k] = shortint'($urandom());
        end
        else
        begin
            span = (mode < 6) ? $urandom_range(1, 64) : $urandom_range(64, 4000);
            for (int k = 0; k < 12; k++)
            begin
                if (k < 3)
                    ctr = int'($urandom_range(0, 60000)) - 30000;
                else
                    ctr = int'(v[k % 3]);
                v[k] = shortint'(ctr + int'($urandom_range(0, 2 * span)) - span);
            end
            if (mode == 9)
            begin
                // collapse the triangle: a repeated vertex or a collinear c
                pick = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                begin
                    if (pick == 0)
                        v[6 + k] = v[3 + k];
                    else if (pick == 1)
                        v[9 + k] = v[6 + k];
                    else
                        v[9 + k] = shortint'(2 * int'(v[6 + k]) - int'(v[3 + k]));
                end
            end
        end
        return pack_item(v);
    endfunction

    task automatic send_item(input logic [IN_W-1:0] d);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_coords(input shortint v[12]);
        send_item(pack_item(v));
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // transfer monitors
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_item(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // vertex, edge and face regions on a plain triangle in the z=0 plane
        send_coords('{-256, -256, 0,    0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        send_coords('{1536, -64, 128,   0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        send_coords('{512, -300, 77,    0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        send_coords('{-10, 2000, -5,    0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        send_coords('{-400, 500, 9,     0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        send_coords('{700, 700, -33,    0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        send_coords('{200, 300, 511,    0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        // point on a vertex and inside the face
        send_coords('{0, 0, 0,          0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        send_coords('{100, 100, 0,      0, 0, 0,   1024, 0, 0,   0, 1024, 0});
        // extreme coordinates
        send_coords('{32767, 32767, 32767,  -32768, -32768, -32768,
                      32767, -32768, 32767,  -32768, 32767, -32768});
        send_coords('{-32768, 32767, -32768,  32767, -32768, 32767,
                      -32768, -32768, 32767,  32767, 32767, -32768});
        send_coords('{0, 0, 32767,  -32768, -32768, -32768,
                      32767, -32768, -32768,  -32768, 32767, -32768});
        send_coords('{-32768, -32768, -32768,  -32768, -32768, -32768,
                      -32768, -32768, -32768,  -32768, -32768, -32768});
        send_coords('{-1, -1, -1,  32767, 32767, 32767,
                      -32768, -32768, -32768,  32767, -32768, 0});
        // degenerate: repeated vertices, and a collinear triangle
        send_coords('{300, 200, 100,   0, 0, 0,   0, 0, 0,   512, 0, 0});
        send_coords('{300, 200, 100,   0, 0, 0,   512, 0, 0,   512, 0, 0});
        send_coords('{512, 300, 0,     0, 0, 0,   256, 0, 0,   1024, 0, 0});
        send_coords('{128, 0, 400,     0, 0, 0,   512, 512, 0,   1024, 1024, 0});
        send_coords('{77, 77, 77,      5, 5, 5,   5, 5, 5,   5, 5, 5});

        for (int i = 0; i < N_RANDOM; i++)
            send_item(random_item());
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
